### rtl/srw_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Selective receive window package
// Shared sizes, codes and record types for the receive window core.
// ----------------------------------------------------------------------------
package srw_pkg;

    localparam int LAST_SEQ       = 512;
    localparam int PEER_COUNT     = 8;
    localparam int WORD_W         = 64;
    localparam int BIT_W          = 6;
    localparam int WORDS_PER_PEER = (LAST_SEQ + WORD_W - 1) / WORD_W;
    localparam int WI_W           = (WORDS_PER_PEER > 1) ? $clog2(WORDS_PER_PEER) : 1;
    localparam int SEQ_IDX_W      = BIT_W + WI_W;
    localparam int NX_W           = SEQ_IDX_W + 1;
    localparam int PEER_W         = (PEER_COUNT > 1) ? $clog2(PEER_COUNT) : 1;
    localparam int RAM_DEPTH      = PEER_COUNT * WORDS_PER_PEER;
    localparam int ADDR_W         = (RAM_DEPTH > 1) ? $clog2(RAM_DEPTH) : 1;

    localparam int QUEUE_DEPTH    = 2;
    localparam int QP_W           = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QC_W           = $clog2(QUEUE_DEPTH + 1);

    localparam int MODE_W         = 2;
    localparam int PEER_ID_W      = 3;
    localparam int SEQ_W          = 32;
    localparam int ACK_W          = 10;
    localparam int IN_DATA_W      = 40;
    localparam int IN_USER_W      = MODE_W;
    localparam int OUT_DATA_W     = 16;
    localparam int OUT_USER_W     = 3;

    localparam logic [MODE_W-1:0] MODE_OPEN  = 2'd0;
    localparam logic [MODE_W-1:0] MODE_DATA  = 2'd1;
    localparam logic [MODE_W-1:0] MODE_CLOSE = 2'd2;

    typedef enum logic [2:0] {
        OP_OPEN,
        OP_CLOSE,
        OP_DATA,
        OP_BAD_DATA,
        OP_UNDEF,
        OP_NO_PEER
    } t_op;

    typedef enum logic [2:0] {
        S_ADVANCED,
        S_COMPLETE,
        S_DUPLICATE,
        S_OLD,
        S_NO_SESSION,
        S_RANGE,
        S_OPENED,
        S_CLOSED
    } t_status;

    typedef enum logic [1:0] {
        W_NONE,
        W_IDLE,
        W_PROG,
        W_DONE
    } t_win;

    typedef enum logic [1:0] {
        BS_IDLE,
        BS_WRITE,
        BS_SCAN,
        BS_EMIT
    } t_bstate;

    typedef struct packed {
        t_op                  op;
        logic [PEER_W-1:0]    peer;
        logic [SEQ_IDX_W-1:0] seq_idx;
    } t_cmd;

    typedef struct packed {
        logic empty;
        logic full;
    } t_q_stat;

    typedef struct packed {
        logic             send_ack;
        logic [ACK_W-1:0] ack;
        t_status          status;
        t_win             win;
    } t_result;

endpackage

### rtl/selective_receive_window_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Selective receive window core
// Per-peer selective-repeat receive windows with cumulative acknowledgements.
// ----------------------------------------------------------------------------
// The slave channel takes one command per transaction: tuser holds the mode
// (open, data arrival, close) and tdata holds the peer and sequence number.
// The master channel returns exactly one result per command, in order.
// A command is classified on entry and waits in a two-entry queue, so the
// slave side keeps accepting until the queue is full while a result is stalled.
// Open, close and rejected commands go from the idle step straight to the emit
// step. A data arrival has a write step that sets its bit; if the packet is
// the next expected one, no clear bit follows it and its word is not the last,
// the forward scan walks one further bitmap word per scan step, over 8 words
// of 64 bits per peer; the single read port of the bitmap RAM sets that pace.
// Reset closes every session and empties every bitmap at once through per-word
// valid bits; no clearing pass is needed. When the master side stalls, the
// finished result holds in the output register and the engine waits.
// ----------------------------------------------------------------------------
module selective_receive_window_core (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_s_tvalid,
    output logic                           o_s_tready,
    // peer_id [2:0], pkt_seq [34:3], zero fill above
    input  logic [srw_pkg::IN_DATA_W-1:0]  i_s_tdata,
    // mode [1:0]
    input  logic [srw_pkg::IN_USER_W-1:0]  i_s_tuser,
    output logic                           o_m_tvalid,
    input  logic                           i_m_tready,
    // send_ack [0], ack_seq [10:1], window_state [12:11], zero fill above
    output logic [srw_pkg::OUT_DATA_W-1:0] o_m_tdata,
    // status [2:0]
    output logic [srw_pkg::OUT_USER_W-1:0] o_m_tuser
);
    import srw_pkg::*;

    t_cmd    push_cmd;
    t_cmd    head_cmd;
    t_q_stat q_stat;
    logic    push;
    logic    pop;
    t_result res;

    srw_front u_front (
        .i_s_tvalid(i_s_tvalid),
        .o_s_tready(o_s_tready),
        .i_s_tdata (i_s_tdata),
        .i_s_tuser (i_s_tuser),
        .i_q       (q_stat),
        .o_push    (push),
        .o_cmd     (push_cmd)
    );

    srw_fifo u_fifo (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_push (push),
        .i_cmd  (push_cmd),
        .i_pop  (pop),
        .o_head (head_cmd),
        .o_q    (q_stat)
    );

    srw_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cmd     (head_cmd),
        .i_q       (q_stat),
        .o_pop     (pop),
        .o_m_tvalid(o_m_tvalid),
        .i_m_tready(i_m_tready),
        .o_res     (res)
    );

    assign o_m_tdata = {3'b000, res.win, res.ack, res.send_ack};
    assign o_m_tuser = res.status;

endmodule

### rtl/srw_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Generic single-port-write RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module srw_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 64
) (
    input  logic                                   i_clk,
    input  logic                                   i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                       i_wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                       o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

### rtl/srw_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Receive window front end
// Accepts input transactions and classifies them into queue commands.
// ----------------------------------------------------------------------------
module srw_front (
    input  logic                           i_s_tvalid,
    output logic                           o_s_tready,
    input  logic [srw_pkg::IN_DATA_W-1:0]  i_s_tdata,
    input  logic [srw_pkg::IN_USER_W-1:0]  i_s_tuser,
    input  srw_pkg::t_q_stat               i_q,
    output logic                           o_push,
    output srw_pkg::t_cmd                  o_cmd
);
    import srw_pkg::*;

    logic [MODE_W-1:0]    mode;
    logic [PEER_ID_W-1:0] peer;
    logic [SEQ_W-1:0]     seq;
    logic                 seq_ok;

    always_comb begin
        mode   = i_s_tuser;
        peer   = i_s_tdata[PEER_ID_W-1:0];
        seq    = i_s_tdata[PEER_ID_W +: SEQ_W];
        seq_ok = (seq != '0) && (seq <= SEQ_W'(LAST_SEQ));

        o_cmd.peer    = PEER_W'(peer);
        o_cmd.seq_idx = SEQ_IDX_W'(seq - SEQ_W'(1));
        if (int'(peer) >= PEER_COUNT) begin
            o_cmd.op = OP_NO_PEER;
        end else begin
            case (mode)
                MODE_OPEN:  o_cmd.op = OP_OPEN;
                MODE_DATA:  o_cmd.op = seq_ok ? OP_DATA : OP_BAD_DATA;
                MODE_CLOSE: o_cmd.op = OP_CLOSE;
                default:    o_cmd.op = OP_UNDEF;
            endcase
        end
    end

    assign o_s_tready = !i_q.full;
    assign o_push     = i_s_tvalid && !i_q.full;

endmodule

### rtl/srw_fifo.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Receive window command queue
// Short queue that decouples the front end from the window engine.
// ----------------------------------------------------------------------------
module srw_fifo (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  srw_pkg::t_cmd    i_cmd,
    input  logic             i_pop,
    output srw_pkg::t_cmd    o_head,
    output srw_pkg::t_q_stat o_q
);
    import srw_pkg::*;

    t_cmd            r_mem [QUEUE_DEPTH];
    logic [QP_W-1:0] r_wp, n_wp;
    logic [QP_W-1:0] r_rp, n_rp;
    logic [QC_W-1:0] r_cnt, n_cnt;

    always_comb begin
        n_wp  = r_wp;
        n_rp  = r_rp;
        n_cnt = r_cnt;
        if (i_push) begin
            n_wp = (r_wp == QP_W'(QUEUE_DEPTH - 1)) ? '0 : r_wp + QP_W'(1);
        end
        if (i_pop) begin
            n_rp = (r_rp == QP_W'(QUEUE_DEPTH - 1)) ? '0 : r_rp + QP_W'(1);
        end
        if (i_push && !i_pop) begin
            n_cnt = r_cnt + QC_W'(1);
        end else if (!i_push && i_pop) begin
            n_cnt = r_cnt - QC_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            r_wp  <= n_wp;
            r_rp  <= n_rp;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_cmd;
        end
    end

    assign o_head  = r_mem[r_rp];
    assign o_q.empty = (r_cnt == '0);
    assign o_q.full  = (r_cnt == QC_W'(QUEUE_DEPTH));

endmodule

### rtl/srw_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Receive window engine
// Executes queued commands on the per-peer windows and the packet bitmap.
// ----------------------------------------------------------------------------
module srw_back (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  srw_pkg::t_cmd    i_cmd,
    input  srw_pkg::t_q_stat i_q,
    output logic             o_pop,
    output logic             o_m_tvalid,
    input  logic             i_m_tready,
    output srw_pkg::t_result o_res
);
    import srw_pkg::*;

    t_bstate               r_state, n_state;
    t_win                  r_sess [PEER_COUNT];
    t_win                  n_sess [PEER_COUNT];
    logic [NX_W-1:0]       r_nxm1 [PEER_COUNT];
    logic [NX_W-1:0]       n_nxm1 [PEER_COUNT];
    logic [RAM_DEPTH-1:0]  r_vld, n_vld;
    t_cmd                  r_cmd, n_cmd;
    logic [WI_W-1:0]       r_word, n_word;
    t_result               r_res, n_res;
    logic                  r_out_vld, n_out_vld;
    t_result               r_out, n_out;

    logic                  ram_we;
    logic [ADDR_W-1:0]     ram_waddr;
    logic [WORD_W-1:0]     ram_wdata;
    logic [ADDR_W-1:0]     ram_raddr;
    logic [WORD_W-1:0]     ram_rdata;

    logic [PEER_W-1:0]     pc;
    t_win                  sess_c;
    logic [NX_W-1:0]       nxm1_c;
    logic [BIT_W-1:0]      bit_pos;
    logic [WI_W-1:0]       wsel;
    logic [ADDR_W-1:0]     cur_addr;
    logic [ADDR_W-1:0]     scan_addr;
    logic [WORD_W-1:0]     new_word;
    logic [WORD_W-1:0]     scan_word;
    logic [BIT_W-1:0]      scan_start;
    logic [WI_W-1:0]       scan_w;
    logic                  found;
    logic [BIT_W-1:0]      zero_bit;
    logic                  scan_done;
    logic [NX_W-1:0]       fin_nx;
    logic [NX_W-1:0]       seq_ext;
    logic                  seq_eq;
    logic                  finish;
    logic                  out_free;

    function automatic logic [ADDR_W-1:0] addr_of(input logic [PEER_W-1:0] peer,
                                                   input logic [WI_W-1:0] w);
        addr_of = ADDR_W'(int'(peer) * WORDS_PER_PEER + int'(w));
    endfunction

    srw_ram #(
        .WIDTH(WORD_W),
        .DEPTH(RAM_DEPTH)
    ) u_bitmap (
        .i_clk  (i_clk),
        .i_we   (ram_we),
        .i_waddr(ram_waddr),
        .i_wdata(ram_wdata),
        .i_raddr(ram_raddr),
        .o_rdata(ram_rdata)
    );

    // Bitmap scan: first clear bit at or above the start position of one word.
    always_comb begin
        logic [WORD_W-1:0] inv;
        logic [WORD_W-1:0] iso;
        pc        = r_cmd.peer;
        sess_c    = r_sess[pc];
        nxm1_c    = r_nxm1[pc];
        bit_pos   = r_cmd.seq_idx[BIT_W-1:0];
        wsel      = r_cmd.seq_idx[SEQ_IDX_W-1 -: WI_W];
        cur_addr  = addr_of(pc, wsel);
        scan_addr = addr_of(pc, r_word);
        new_word  = (r_vld[cur_addr] ? ram_rdata : '0) | (WORD_W'(1) << bit_pos);
        seq_ext   = NX_W'(r_cmd.seq_idx);
        seq_eq    = (seq_ext == nxm1_c);

        if (r_state == BS_WRITE) begin
            scan_word  = new_word;
            scan_start = bit_pos;
            scan_w     = wsel;
        end else begin
            scan_word  = r_vld[scan_addr] ? ram_rdata : '0;
            scan_start = '0;
            scan_w     = r_word;
        end

        inv      = ~(scan_word | ((WORD_W'(1) << scan_start) - WORD_W'(1)));
        iso      = inv & (~inv + WORD_W'(1));
        found    = |inv;
        zero_bit = '0;
        for (int i = 0; i < WORD_W; i++) begin
            if (iso[i]) begin
                zero_bit = zero_bit | BIT_W'(i);
            end
        end

        scan_done = found || (scan_w == WI_W'(WORDS_PER_PEER - 1));
        fin_nx    = found ? NX_W'({scan_w, zero_bit})
                          : (NX_W'(scan_w) + NX_W'(1)) << BIT_W;
        finish    = ((r_state == BS_WRITE) && seq_eq && scan_done) ||
                    ((r_state == BS_SCAN) && scan_done);
        out_free  = !r_out_vld || i_m_tready;
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            BS_IDLE: begin
                if (!i_q.empty) begin
                    if (i_cmd.op == OP_DATA && r_sess[i_cmd.peer] != W_NONE) begin
                        n_state = BS_WRITE;
                    end else begin
                        n_state = BS_EMIT;
                    end
                end
            end
            BS_WRITE: begin
                n_state = (seq_eq && !scan_done) ? BS_SCAN : BS_EMIT;
            end
            BS_SCAN: begin
                n_state = scan_done ? BS_EMIT : BS_SCAN;
            end
            BS_EMIT: begin
                n_state = out_free ? BS_IDLE : BS_EMIT;
            end
            default: begin
                n_state = BS_IDLE;
            end
        endcase
    end

    always_comb begin
        n_sess    = r_sess;
        n_nxm1    = r_nxm1;
        n_vld     = r_vld;
        n_cmd     = r_cmd;
        n_word    = r_word;
        n_res     = r_res;
        n_out     = r_out;
        n_out_vld = r_out_vld && !i_m_tready;
        o_pop     = 1'b0;
        ram_we    = 1'b0;
        ram_waddr = cur_addr;
        ram_wdata = new_word;
        ram_raddr = addr_of(pc, WI_W'(r_word + WI_W'(1)));

        case (r_state)
            BS_IDLE: begin
                ram_raddr = addr_of(i_cmd.peer, i_cmd.seq_idx[SEQ_IDX_W-1 -: WI_W]);
                if (!i_q.empty) begin
                    o_pop = 1'b1;
                    n_cmd = i_cmd;
                    case (i_cmd.op)
                        OP_OPEN: begin
                            n_sess[i_cmd.peer] = W_IDLE;
                            n_nxm1[i_cmd.peer] = '0;
                            for (int i = 0; i < RAM_DEPTH; i++) begin
                                if (i / WORDS_PER_PEER == int'(i_cmd.peer)) begin
                                    n_vld[i] = 1'b0;
                                end
                            end
                            n_res = '{send_ack: 1'b0, ack: '0, status: S_OPENED,
                                      win: W_IDLE};
                        end
                        OP_CLOSE: begin
                            n_sess[i_cmd.peer] = W_NONE;
                            n_res = '{send_ack: 1'b0, ack: '0, status: S_CLOSED,
                                      win: W_NONE};
                        end
                        OP_NO_PEER: begin
                            n_res = '{send_ack: 1'b0, ack: '0, status: S_NO_SESSION,
                                      win: W_NONE};
                        end
                        default: begin
                            if (r_sess[i_cmd.peer] == W_NONE) begin
                                n_res = '{send_ack: 1'b0, ack: '0,
                                          status: (i_cmd.op == OP_UNDEF) ? S_RANGE
                                                                         : S_NO_SESSION,
                                          win: W_NONE};
                            end else if (i_cmd.op != OP_DATA) begin
                                n_res = '{send_ack: 1'b0,
                                          ack: ACK_W'(r_nxm1[i_cmd.peer]),
                                          status: S_RANGE,
                                          win: r_sess[i_cmd.peer]};
                            end else if (r_sess[i_cmd.peer] == W_IDLE) begin
                                n_sess[i_cmd.peer] = W_PROG;
                            end
                        end
                    endcase
                end
            end
            BS_WRITE: begin
                ram_we          = 1'b1;
                n_vld[cur_addr] = 1'b1;
                ram_raddr       = addr_of(pc, WI_W'(wsel + WI_W'(1)));
                n_word          = WI_W'(wsel + WI_W'(1));
                if (!seq_eq) begin
                    n_res = '{send_ack: (seq_ext > nxm1_c), ack: ACK_W'(nxm1_c),
                              status: (seq_ext > nxm1_c) ? S_DUPLICATE : S_OLD,
                              win: sess_c};
                end
            end
            BS_SCAN: begin
                n_word = WI_W'(r_word + WI_W'(1));
            end
            BS_EMIT: begin
                if (out_free) begin
                    n_out     = r_res;
                    n_out_vld = 1'b1;
                end
            end
            default: begin
            end
        endcase

        if (finish) begin
            n_nxm1[pc] = fin_nx;
            if (fin_nx == NX_W'(LAST_SEQ)) begin
                n_sess[pc] = W_DONE;
                n_res = '{send_ack: 1'b1, ack: ACK_W'(fin_nx), status: S_COMPLETE,
                          win: W_DONE};
            end else begin
                n_res = '{send_ack: 1'b1, ack: ACK_W'(fin_nx), status: S_ADVANCED,
                          win: sess_c};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= BS_IDLE;
            r_vld     <= '0;
            r_out_vld <= 1'b0;
            for (int i = 0; i < PEER_COUNT; i++) begin
                r_sess[i] <= W_NONE;
                r_nxm1[i] <= '0;
            end
        end else begin
            r_state   <= n_state;
            r_vld     <= n_vld;
            r_out_vld <= n_out_vld;
            r_sess    <= n_sess;
            r_nxm1    <= n_nxm1;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmd  <= n_cmd;
        r_word <= n_word;
        r_res  <= n_res;
        r_out  <= n_out;
    end

    assign o_m_tvalid = r_out_vld;
    assign o_res      = r_out;

`ifndef NO_ASSERTIONS
    a_write_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ram_we |-> r_state == BS_WRITE)
        else $error("Bitmap written outside the write step.");

    a_scan_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == BS_SCAN |-> r_word != '0)
        else $error("Scan continued on the word of the arriving packet.");

    a_pop_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_pop |=> r_state != BS_IDLE)
        else $error("Command popped without being executed.");

    a_emit_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == BS_EMIT && r_out_vld && !i_m_tready) |=> r_state == BS_EMIT)
        else $error("Result dropped while the output register was full.");
`endif

endmodule
